// File: sv/pn3d_pkg.sv
// ----------------------------------------------------------------------------
// pn3d_pkg: shared constants, permutation table and helpers for 3D noise
// Holds the fixed permutation, the gradient codes and fixed-point widths.
// ----------------------------------------------------------------------------
package pn3d_pkg;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_W        = 24;
  localparam int OUT_W          = 18;
  localparam int OUT_FRAC       = 16;
  localparam int ROM_DEPTH      = 256;

  typedef logic [7:0] perm_t;

  // fixed reference permutation
  localparam perm_t PERM [ROM_DEPTH] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,
    8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,
    8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,
    8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,
    8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,
    8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,
    8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,
    8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,
    8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,
    8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,
    8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,
    8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,
    8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
    8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,
    8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  // gradient codes
  localparam logic [3:0] G_XPY = 4'h0, G_NXPY = 4'h1, G_XMY = 4'h2, G_NXMY = 4'h3,
                         G_XPZ = 4'h4, G_NXPZ = 4'h5, G_XMZ = 4'h6, G_NXMZ = 4'h7,
                         G_YPZ = 4'h8, G_NYPZ = 4'h9, G_YMZ = 4'hA, G_NYMZ = 4'hB,
                         G_YPX = 4'hC, G_NYPZ2 = 4'hD, G_YMX = 4'hE;

  // look up permutation, index taken modulo the table
  function automatic perm_t perm_rd(input logic [7:0] idx);
    return PERM[idx];
  endfunction

endpackage

// File: sv/pn3d_fade.sv
// ----------------------------------------------------------------------------
// pn3d_fade: pipelined quintic fade
// Five registered steps of 6t^5-15t^4+10t^3 using floor shifts.
// ----------------------------------------------------------------------------
module pn3d_fade #(
  parameter int FRAC_BITS = pn3d_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] f_in,
  output logic [FRAC_BITS:0]   u_out
);
  localparam int W  = FRAC_BITS + 6;
  localparam int PW = W + FRAC_BITS + 2;
  localparam logic signed [W-1:0] S15 = W'(15) <<< FRAC_BITS;
  localparam logic signed [W-1:0] S10 = W'(10) <<< FRAC_BITS;

  logic [FRAC_BITS-1:0] f_r [4];
  logic signed [W-1:0]  a_r, b_r, c_r, d_r;
  logic signed [PW-1:0] pb, pc, pd, pu;
  logic [FRAC_BITS:0]   u_r;

  assign pb = $signed({2'b0, f_r[0]}) * a_r;
  assign pc = $signed({2'b0, f_r[1]}) * b_r;
  assign pd = $signed({2'b0, f_r[2]}) * c_r;
  assign pu = $signed({2'b0, f_r[3]}) * d_r;

  // advance one step per stage; each stage after the first adds a multiply
  always_ff @(posedge clk) begin
    if (en) begin
      f_r[0] <= f_in;
      a_r    <= $signed(W'({f_in, 2'b0}) + W'({f_in, 1'b0})) - S15;
      f_r[1] <= f_r[0];
      b_r    <= W'(pb >>> FRAC_BITS) + S10;
      f_r[2] <= f_r[1];
      c_r    <= W'(pc >>> FRAC_BITS);
      f_r[3] <= f_r[2];
      d_r    <= W'(pd >>> FRAC_BITS);
      u_r    <= (FRAC_BITS+1)'(pu >>> FRAC_BITS);
    end
  end
  assign u_out = u_r;
endmodule

// File: sv/perlin_noise_3d_top.sv
// ----------------------------------------------------------------------------
// perlin_noise_3d_top: improved 3D gradient noise; unless stalled, one point per cycle
// ----------------------------------------------------------------------------
// Usage: present a point on in_coord_x/y/z with in_valid; it is taken at a
// rising edge with in_valid high and in_stall low. Each coordinate carries
// the lattice cell above FRAC_BITS and the cell fraction below it.
// One noise value (signed, 16 fraction bits, saturated) leaves on
// out_noise_value with out_valid; the receiver holds it with out_stall.
// Throughput is one item per cycle while out_stall holds no valid result, in a
// nine-stage pipeline: fade multiplies and hash lookups, corner gradients,
// three lerp levels and a saturating output stage.
// The whole pipeline advances together; while out_stall holds a valid
// result, every stage freezes and in_stall is raised, so nothing is lost
// or repeated. Bubbles travel with cleared valid bits.
// Reset (rst_n low, synchronous) clears all valid bits; the permutation is
// a constant table and needs no fill.
// ----------------------------------------------------------------------------
module perlin_noise_3d_top #(
  parameter int TABLE_SIZE = pn3d_pkg::TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = pn3d_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pn3d_pkg::COORD_W-1:0] in_coord_x,
  input  logic [pn3d_pkg::COORD_W-1:0] in_coord_y,
  input  logic [pn3d_pkg::COORD_W-1:0] in_coord_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [pn3d_pkg::OUT_W-1:0] out_noise_value
);
  localparam int NST   = 9;
  localparam int F     = FRAC_BITS;
  localparam int TB    = $clog2(TABLE_SIZE);
  localparam int RW    = F + 1;           // relative coordinate, signed
  localparam int GW    = F + 3;           // gradient sum
  localparam int LW    = F + 4;           // lerp value
  localparam int MW    = LW + F + 3;
  localparam logic [7:0] RMASK = 8'((TABLE_SIZE - 1) & 255);
  localparam logic [TB-1:0] TMASK = TB'(TABLE_SIZE - 1);

  typedef logic [7:0] h_t;

  logic            adv;
  logic [NST-1:0]  vld_r;

  // one stall for the whole pipe
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // stage 0: split coordinates
  logic [F-1:0]  xf_r [NST], yf_r [NST], zf_r [NST];
  logic [TB-1:0] xi_r, yi_r, zi_r;
  logic [TB-1:0] xi_w, yi_w, zi_w;
  assign xi_w = TB'(in_coord_x >> F) & TMASK;
  assign yi_w = TB'(in_coord_y >> F) & TMASK;
  assign zi_w = TB'(in_coord_z >> F) & TMASK;

  always_ff @(posedge clk) begin
    if (adv) begin
      xf_r[0] <= in_coord_x[F-1:0];
      yf_r[0] <= in_coord_y[F-1:0];
      zf_r[0] <= in_coord_z[F-1:0];
      xi_r <= xi_w; yi_r <= yi_w; zi_r <= zi_w;
      for (int i = 1; i < NST; i++) begin
        xf_r[i] <= xf_r[i-1];
        yf_r[i] <= yf_r[i-1];
        zf_r[i] <= zf_r[i-1];
      end
    end
  end

  // fade units, 5 stages from in; aligned below
  logic [F:0] u_w, v_w, w_w;
  pn3d_fade #(.FRAC_BITS(F)) u_fade (.clk, .en(adv), .f_in(in_coord_x[F-1:0]), .u_out(u_w));
  pn3d_fade #(.FRAC_BITS(F)) v_fade (.clk, .en(adv), .f_in(in_coord_y[F-1:0]), .u_out(v_w));
  pn3d_fade #(.FRAC_BITS(F)) w_fade (.clk, .en(adv), .f_in(in_coord_z[F-1:0]), .u_out(w_w));

  // hash stage 1: a, b
  h_t a_r, b_r;
  logic [TB-1:0] zi1_r;
  logic [7:0] xi8, yi8, zi8;
  assign xi8 = 8'(xi_r); assign yi8 = 8'(yi_r); assign zi8 = 8'(zi1_r);

  // hash stage 2: aa, ab, ba, bb ; stage 3: corner hashes
  h_t aa_r, ab_r, ba_r, bb_r;
  logic [3:0] hc_r [8];

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r   <= pn3d_pkg::perm_rd(xi8 & RMASK) + yi8;
      b_r   <= pn3d_pkg::perm_rd(8'(xi8 + 8'd1) & RMASK) + yi8;
      zi1_r <= zi_r;
      aa_r  <= pn3d_pkg::perm_rd(a_r & RMASK) + zi8;
      ab_r  <= pn3d_pkg::perm_rd(8'(a_r + 8'd1) & RMASK) + zi8;
      ba_r  <= pn3d_pkg::perm_rd(b_r & RMASK) + zi8;
      bb_r  <= pn3d_pkg::perm_rd(8'(b_r + 8'd1) & RMASK) + zi8;
      hc_r[0] <= 4'(pn3d_pkg::perm_rd(aa_r & RMASK));
      hc_r[1] <= 4'(pn3d_pkg::perm_rd(ba_r & RMASK));
      hc_r[2] <= 4'(pn3d_pkg::perm_rd(ab_r & RMASK));
      hc_r[3] <= 4'(pn3d_pkg::perm_rd(bb_r & RMASK));
      hc_r[4] <= 4'(pn3d_pkg::perm_rd(8'(aa_r + 8'd1) & RMASK));
      hc_r[5] <= 4'(pn3d_pkg::perm_rd(8'(ba_r + 8'd1) & RMASK));
      hc_r[6] <= 4'(pn3d_pkg::perm_rd(8'(ab_r + 8'd1) & RMASK));
      hc_r[7] <= 4'(pn3d_pkg::perm_rd(8'(bb_r + 8'd1) & RMASK));
    end
  end

  // gradient select
  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
      input logic signed [RW-1:0] x, input logic signed [RW-1:0] y,
      input logic signed [RW-1:0] z);
    logic signed [GW-1:0] gx, gy, gz, r;
    gx = GW'(x); gy = GW'(y); gz = GW'(z);
    case (h)
      pn3d_pkg::G_XPY:   r = gx + gy;
      pn3d_pkg::G_NXPY:  r = gy - gx;
      pn3d_pkg::G_XMY:   r = gx - gy;
      pn3d_pkg::G_NXMY:  r = -gx - gy;
      pn3d_pkg::G_XPZ:   r = gx + gz;
      pn3d_pkg::G_NXPZ:  r = gz - gx;
      pn3d_pkg::G_XMZ:   r = gx - gz;
      pn3d_pkg::G_NXMZ:  r = -gx - gz;
      pn3d_pkg::G_YPZ:   r = gy + gz;
      pn3d_pkg::G_NYPZ:  r = gz - gy;
      pn3d_pkg::G_YMZ:   r = gy - gz;
      pn3d_pkg::G_NYMZ:  r = -gy - gz;
      pn3d_pkg::G_YPX:   r = gy + gx;
      pn3d_pkg::G_NYPZ2: r = gz - gy;
      pn3d_pkg::G_YMX:   r = gy - gx;
      default:           r = -gy - gz;
    endcase
    return r;
  endfunction

  // stage 4: corner gradients (fractions from stage slot 3)
  logic signed [RW-1:0] x0, y0, z0, x1, y1, z1;
  assign x0 = $signed({1'b0, xf_r[3]});
  assign y0 = $signed({1'b0, yf_r[3]});
  assign z0 = $signed({1'b0, zf_r[3]});
  assign x1 = x0 - $signed(RW'(1) << F);
  assign y1 = y0 - $signed(RW'(1) << F);
  assign z1 = z0 - $signed(RW'(1) << F);

  logic signed [LW-1:0] g_r [8];
  logic [F:0] v_r, w_r, w2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      g_r[0] <= LW'(grad(hc_r[0], x0, y0, z0));
      g_r[1] <= LW'(grad(hc_r[1], x1, y0, z0));
      g_r[2] <= LW'(grad(hc_r[2], x0, y1, z0));
      g_r[3] <= LW'(grad(hc_r[3], x1, y1, z0));
      g_r[4] <= LW'(grad(hc_r[4], x0, y0, z1));
      g_r[5] <= LW'(grad(hc_r[5], x1, y0, z1));
      g_r[6] <= LW'(grad(hc_r[6], x0, y1, z1));
      g_r[7] <= LW'(grad(hc_r[7], x1, y1, z1));
      // fade outputs feed stage 5; v and w are delayed to their lerp levels
      v_r  <= v_w;
      w_r  <= w_w;  w2_r <= w_r;
    end
  end

  function automatic logic signed [LW-1:0] lerp(input logic [F:0] t,
      input logic signed [LW-1:0] p, input logic signed [LW-1:0] q);
    logic signed [MW-1:0] m;
    m = $signed({1'b0, t}) * (MW'(q) - MW'(p));
    return p + LW'(m >>> F);
  endfunction

  // stages 5-7: lerp tree
  logic signed [LW-1:0] l1_r [4], l2_r [2], l3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) l1_r[i] <= lerp(u_w, g_r[2*i], g_r[2*i+1]);
      l2_r[0] <= lerp(v_r, l1_r[0], l1_r[1]);
      l2_r[1] <= lerp(v_r, l1_r[2], l1_r[3]);
      l3_r    <= lerp(w2_r, l2_r[0], l2_r[1]);
    end
  end

  // stage 8: rescale and saturate
  localparam int SW = LW + 16;
  logic signed [SW-1:0] sc;
  logic signed [pn3d_pkg::OUT_W-1:0] o_r;
  localparam logic signed [SW-1:0] OMAX = SW'(131071);
  localparam logic signed [SW-1:0] OMIN = -SW'(131072);
  always_comb begin
    if (F > pn3d_pkg::OUT_FRAC) sc = SW'(l3_r) >>> (F - pn3d_pkg::OUT_FRAC);
    else                         sc = SW'(l3_r) <<< (pn3d_pkg::OUT_FRAC - F);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      if (sc > OMAX)      o_r <= pn3d_pkg::OUT_W'(OMAX);
      else if (sc < OMIN) o_r <= pn3d_pkg::OUT_W'(OMIN);
      else                o_r <= pn3d_pkg::OUT_W'(sc);
    end
  end
  assign out_noise_value = o_r;

`ifndef SYNTH
  // stalled output holds its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_noise_value))
    else $error("output changed under stall");
  // stall only when output is blocked
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("stall mismatch");
  // accepted item sets the first stage's valid bit
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && $past(adv) |=> vld_r[0])
    else $error("valid bit lost");
`endif
endmodule
